// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define KBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// concurrent check on the rising clock edge that also holds during reset
`define KBD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/kbd_pkg.sv -----
// shared types, constants and helpers for the keyboard ring buffer device
package kbd_pkg;

	// sizes
	localparam int QueueDepth = 64;
	localparam int KeyCount   = 256;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int MapIdxW    = $clog2(KeyCount);

	// special key codes and printable range
	localparam logic [7:0] KeyShift   = 8'h90;
	localparam logic [7:0] KeyControl = 8'h91;
	localparam logic [7:0] PrintLow   = 8'h20;
	localparam logic [7:0] PrintHigh  = 8'h7f;
	localparam logic [7:0] LetterLow  = 8'h41;
	localparam logic [7:0] LetterHigh = 8'h5a;
	localparam logic [7:0] CaseOffset = 8'h20;

	// register byte address select
	localparam logic RegIrqMessage = 1'b0;

	// item kinds
	typedef enum logic [2:0] {
		KIND_KEY   = 3'd0,
		KIND_CHAR  = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_POP   = 3'd3,
		KIND_TEST  = 3'd4,
		KIND_TICK  = 3'd5
	} kind_t;

	// command to the key queue
	typedef struct packed {
		logic       push;
		logic [7:0] code;
		logic       clear;
		logic       pop;
	} qcmd_t;

	// key event to the pressed map
	typedef struct packed {
		logic       valid;
		logic [7:0] key;
		logic       right;
		logic       down;
	} mev_t;

	// key code lies inside the pressed map
	function automatic logic key_in_map(input logic [7:0] k);
		return ({1'b0, k} < 9'(KeyCount));
	endfunction

endpackage

// ----- rtl/kbd_ram.sv -----
// generic single write port ram with registered read
module kbd_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/kbd_queue.sv -----
// key ring queue: pointers, drop of oldest entry when full, storage ram
module kbd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  kbd_pkg::qcmd_t      cmd,
	output logic                pop_hit,
	output logic                empty,
	output logic [7:0]          rdata
);

	logic [kbd_pkg::PtrW-1:0] wptr_q;
	logic [kbd_pkg::PtrW-1:0] rptr_q;
	logic [kbd_pkg::PtrW-1:0] wptr_next;
	logic [kbd_pkg::PtrW-1:0] rptr_next;

	// ring increment
	function automatic logic [kbd_pkg::PtrW-1:0] next_slot(input logic [kbd_pkg::PtrW-1:0] p);
		return (p == kbd_pkg::PtrW'(kbd_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wptr_next = next_slot(wptr_q);
	assign rptr_next = next_slot(rptr_q);
	assign empty     = (wptr_q == rptr_q);
	assign pop_hit   = cmd.pop && !empty;

	// pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (cmd.clear) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (cmd.push) begin
			wptr_q <= wptr_next;
			// full: drop the oldest key
			if (rptr_q == wptr_next) begin
				rptr_q <= rptr_next;
			end
		end else if (pop_hit) begin
			rptr_q <= rptr_next;
		end
	end

	kbd_ram #(
		.Width (8),
		.Depth (kbd_pkg::QueueDepth)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wptr_q),
		.wdata (cmd.code),
		.re    (pop_hit),
		.raddr (rptr_q),
		.rdata (rdata)
	);

endmodule

// ----- rtl/kbd_map.sv -----
// pressed-key map with merged shift and control bits
module kbd_map (
	input  logic          clk,
	input  logic          arst_n,
	input  kbd_pkg::mev_t ev,
	input  logic [7:0]    test_key,
	output logic          is_down
);

	logic [kbd_pkg::KeyCount-1:0] map_q;
	logic                         shift_l_q;
	logic                         shift_r_q;
	logic                         ctrl_l_q;
	logic                         ctrl_r_q;
	logic [7:0]                   mirror_key;
	logic                         is_letter;

	assign mirror_key = ev.key + kbd_pkg::CaseOffset;
	assign is_letter  = (ev.key >= kbd_pkg::LetterLow) && (ev.key <= kbd_pkg::LetterHigh);

	// map and modifier update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q     <= '0;
			shift_l_q <= 1'b0;
			shift_r_q <= 1'b0;
			ctrl_l_q  <= 1'b0;
			ctrl_r_q  <= 1'b0;
		end else if (ev.valid) begin
			priority if (ev.key == kbd_pkg::KeyShift) begin
				if (ev.right) begin
					shift_r_q <= ev.down;
				end else begin
					shift_l_q <= ev.down;
				end
				if (kbd_pkg::key_in_map(ev.key)) begin
					map_q[ev.key[kbd_pkg::MapIdxW-1:0]] <=
						ev.right ? (ev.down | shift_l_q) : (ev.down | shift_r_q);
				end
			end else if (ev.key == kbd_pkg::KeyControl) begin
				if (ev.right) begin
					ctrl_r_q <= ev.down;
				end else begin
					ctrl_l_q <= ev.down;
				end
				if (kbd_pkg::key_in_map(ev.key)) begin
					map_q[ev.key[kbd_pkg::MapIdxW-1:0]] <=
						ev.right ? (ev.down | ctrl_l_q) : (ev.down | ctrl_r_q);
				end
			end else begin
				if (kbd_pkg::key_in_map(ev.key)) begin
					map_q[ev.key[kbd_pkg::MapIdxW-1:0]] <= ev.down;
				end
				// uppercase letters mirror to lowercase
				if (is_letter && kbd_pkg::key_in_map(mirror_key)) begin
					map_q[mirror_key[kbd_pkg::MapIdxW-1:0]] <= ev.down;
				end
			end
		end
	end

	// key test, key zero and keys beyond the map read as released
	always_comb begin
		is_down = 1'b0;
		if (test_key != 8'd0 && kbd_pkg::key_in_map(test_key)) begin
			is_down = map_q[test_key[kbd_pkg::MapIdxW-1:0]];
		end
	end

endmodule

// ----- rtl/keyboard_ring_buffer_device.sv -----
// top level of the keyboard device: item stages, interrupt and register port
//
// Input beats carry key events, typed characters, clear, pop, test and tick
// items: the kind in s_tuser, the key, side and down flags in s_tdata.
// Pop and test items always give one output beat; a tick gives one only when
// a pending interrupt fires with a nonzero message. Other items give none.
// An accepted item waits in the input stage, where the map, queue
// pointers and interrupt flag are updated, and its result is loaded into the
// output register once that register is free; m_tvalid is that register's valid.
// One item per cycle is sustained while m_tready stays high; the queue ram
// read on a pop lands in the output register with the rest of the result.
// When m_tready is low the result holds, the input stage keeps one more item
// and s_tready drops; nothing is lost or reordered.
// Reset empties the queue, releases every key, clears the modifier bits, the
// pending interrupt and the interrupt message register. Queue entries are
// not cleared; no entry is read before it is written.
// The interrupt message register sits at byte address 0 of the APB port and
// is to be written by the user only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module keyboard_ring_buffer_device (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // key_index[7:0], modifier_side[8], key_down[9], zero[15:10]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_data[7:0], is_down[8], irq_fire[9], irq_value[25:10],
	                              // zero[31:26]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// input stage
	logic                valid_s1;
	kbd_pkg::kind_t      kind_s1;
	logic [7:0]          key_s1;
	logic                right_s1;
	logic                down_s1;

	// result stage
	logic                valid_s2;
	logic                pop_hit_s2;
	logic                is_down_s2;
	logic                fire_s2;
	logic [15:0]         value_s2;

	logic [15:0]         irq_msg_q;
	logic                irq_pending_q;

	logic                adv;
	logic                go;
	logic                has_result;
	logic                fire;
	logic                queue_key;
	kbd_pkg::qcmd_t      qcmd;
	kbd_pkg::mev_t       mev;
	logic                pop_hit;
	logic                q_empty;
	logic [7:0]          q_rdata;
	logic                is_down;

	// flow control
	assign adv      = !valid_s2 || m_tready;
	assign go       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= kbd_pkg::kind_t'(s_tuser);
			key_s1   <= s_tdata[7:0];
			right_s1 <= s_tdata[8];
			down_s1  <= s_tdata[9];
		end
	end

	// decode of the item in the input stage
	assign queue_key = down_s1 && ((key_s1 < kbd_pkg::PrintLow) || (key_s1 > kbd_pkg::PrintHigh))
		&& kbd_pkg::key_in_map(key_s1);
	assign fire = irq_pending_q && (irq_msg_q != 16'd0);

	always_comb begin
		qcmd       = '0;
		mev        = '0;
		has_result = 1'b0;
		mev.key    = key_s1;
		mev.right  = right_s1;
		mev.down   = down_s1;
		qcmd.code  = key_s1;
		unique case (kind_s1)
			kbd_pkg::KIND_KEY: begin
				mev.valid = go;
				qcmd.push = go && queue_key;
			end
			kbd_pkg::KIND_CHAR: begin
				qcmd.push = go && kbd_pkg::key_in_map(key_s1);
			end
			kbd_pkg::KIND_CLEAR: begin
				qcmd.clear = go;
			end
			kbd_pkg::KIND_POP: begin
				qcmd.pop   = go;
				has_result = 1'b1;
			end
			kbd_pkg::KIND_TEST: begin
				has_result = 1'b1;
			end
			kbd_pkg::KIND_TICK: begin
				has_result = fire;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// pending interrupt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_pending_q <= 1'b0;
		end else if (go && kind_s1 == kbd_pkg::KIND_KEY) begin
			if (irq_msg_q != 16'd0) begin
				irq_pending_q <= 1'b1;
			end
		end else if (go && kind_s1 == kbd_pkg::KIND_TICK) begin
			irq_pending_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= go && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pop_hit_s2 <= pop_hit;
			is_down_s2 <= (kind_s1 == kbd_pkg::KIND_TEST) && is_down;
			fire_s2    <= (kind_s1 == kbd_pkg::KIND_TICK) && fire;
			value_s2   <= ((kind_s1 == kbd_pkg::KIND_TICK) && fire) ? irq_msg_q : 16'd0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, value_s2, fire_s2, is_down_s2, pop_hit_s2 ? q_rdata : 8'd0};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_msg_q <= 16'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == kbd_pkg::RegIrqMessage) begin
			irq_msg_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kbd_pkg::RegIrqMessage) ? {16'd0, irq_msg_q} : 32'd0;

	kbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (qcmd),
		.pop_hit (pop_hit),
		.empty   (q_empty),
		.rdata   (q_rdata)
	);

	kbd_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (mev),
		.test_key (key_s1),
		.is_down  (is_down)
	);

	// checks
	`KBD_ASSERT(a_fire_has_message, fire_s2 |-> (value_s2 != 16'd0), "irq fired with zero message")
	`KBD_ASSERT(a_one_result_kind, valid_s2 |-> ($countones({pop_hit_s2, is_down_s2, fire_s2}) <= 1),
		"result mixes several kinds")
	`KBD_ASSERT(a_clear_empties, (go && kind_s1 == kbd_pkg::KIND_CLEAR) |=> q_empty,
		"queue not empty after clear")
	`KBD_ASSERT(a_idle_tick_silent,
		(go && kind_s1 == kbd_pkg::KIND_TICK && !irq_pending_q) |=> !m_tvalid,
		"tick without pending interrupt gave a result")

endmodule

// ----- bench/keyboard_ring_buffer_device_tb.sv -----
// self-checking testbench for the keyboard ring buffer device
`timescale 1ns / 100ps

module keyboard_ring_buffer_device_tb;

	localparam int IdleLimit = 2000;
	localparam int PhaseItems = 240;
	localparam logic [2:0] MsgAddr = {kbd_pkg::RegIrqMessage, 2'b00};
	localparam logic [2:0] SpareAddr = {~kbd_pkg::RegIrqMessage, 2'b00};
	localparam logic [2:0] KindSpareLo = 3'd6;
	localparam logic [2:0] KindSpareHi = 3'd7;

	// one input beat below the kind, packed as in s_tdata
	typedef struct packed {
		logic       down;
		logic       side;
		logic [7:0] key;
	} key_fields_t;

	// one result beat, packed as in m_tdata
	typedef struct packed {
		logic [15:0] irq_value;
		logic        irq_fire;
		logic        is_down;
		logic [7:0]  read_data;
	} kbd_result_t;

	localparam kbd_result_t NoBeat = '0;

	typedef enum logic [1:0] {ROW_ITEM, ROW_MSG_WRITE, ROW_SPARE_WRITE} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [2:0]  kind;
		logic [7:0]  key;
		logic        side;
		logic        down;
		logic [31:0] value;
		logic        typed;
		kbd_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // key_index[7:0], modifier_side[8], key_down[9], zero[15:10]
	logic [2:0]  s_tuser = '0;  // kind[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // read_data[7:0], is_down[8], irq_fire[9], irq_value[25:10], zero[31:26]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	keyboard_ring_buffer_device uut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow keyboard state
	logic [kbd_pkg::KeyCount-1:0] key_map = '0;
	logic                         shift_l = 1'b0, shift_r = 1'b0, ctrl_l = 1'b0, ctrl_r = 1'b0;
	logic                         irq_armed = 1'b0;
	logic [15:0]                  irq_msg = '0;
	logic [7:0]                   key_fifo [kbd_pkg::QueueDepth];
	logic [kbd_pkg::PtrW-1:0]     fifo_wr = '0, fifo_rd = '0;

	kbd_result_t awaited_responses [$];

	int mismatch_count = 0;
	int items_sent = 0, beats_checked = 0, irqs_seen = 0, fifo_drops = 0, keys_found_down = 0;
	int burst_left = 0;
	int quiet_cycles = 0;

	function automatic void flag_error(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	// append to the shadow ring, dropping the oldest key when full
	function automatic void fifo_append(input logic [7:0] code);
		key_fifo[fifo_wr] = code;
		fifo_wr = fifo_wr + 1'b1;
		if (fifo_rd == fifo_wr) begin
			fifo_rd = fifo_rd + 1'b1;
			fifo_drops++;
		end
	endfunction

	// next state and response of the keyboard for one accepted beat
	function automatic void keyboard_response(input logic [2:0] kind, input key_fields_t f,
			output logic has_res, output kbd_result_t res);
		has_res = 1'b0;
		res = NoBeat;
		case (kind)
			kbd_pkg::KIND_KEY: begin
				if (f.key == kbd_pkg::KeyShift) begin
					if (f.side) shift_r = f.down;
					else shift_l = f.down;
					key_map[kbd_pkg::KeyShift] = shift_l | shift_r;
				end else if (f.key == kbd_pkg::KeyControl) begin
					if (f.side) ctrl_r = f.down;
					else ctrl_l = f.down;
					key_map[kbd_pkg::KeyControl] = ctrl_l | ctrl_r;
				end else begin
					key_map[f.key] = f.down;
					// uppercase letters mirror to lowercase
					if (f.key >= kbd_pkg::LetterLow && f.key <= kbd_pkg::LetterHigh)
						key_map[f.key + kbd_pkg::CaseOffset] = f.down;
				end
				if (f.down && (f.key < kbd_pkg::PrintLow || f.key > kbd_pkg::PrintHigh))
					fifo_append(f.key);
				if (irq_msg != 0)
					irq_armed = 1'b1;
			end
			kbd_pkg::KIND_CHAR: fifo_append(f.key);
			kbd_pkg::KIND_CLEAR: begin
				fifo_wr = '0;
				fifo_rd = '0;
			end
			kbd_pkg::KIND_POP: begin
				has_res = 1'b1;
				if (fifo_rd != fifo_wr) begin
					res.read_data = key_fifo[fifo_rd];
					fifo_rd = fifo_rd + 1'b1;
				end
			end
			kbd_pkg::KIND_TEST: begin
				has_res = 1'b1;
				// key zero never reads as down
				if (f.key != 8'h00)
					res.is_down = key_map[f.key];
				if (res.is_down)
					keys_found_down++;
			end
			kbd_pkg::KIND_TICK: begin
				if (irq_armed) begin
					irq_armed = 1'b0;
					if (irq_msg != 0) begin
						has_res = 1'b1;
						res.irq_fire = 1'b1;
						res.irq_value = irq_msg;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// key codes that exercise the modifiers, letter mirroring and queueing
	function automatic logic [7:0] pick_key();
		if ($urandom_range(0, 9) < 4)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0: return kbd_pkg::KeyShift;
			1: return kbd_pkg::KeyControl;
			2: return kbd_pkg::LetterLow + 8'($urandom_range(0, 25));
			3: return kbd_pkg::LetterLow + kbd_pkg::CaseOffset + 8'($urandom_range(0, 25));
			4: return 8'($urandom_range(0, 31));
			5: return 8'($urandom_range(128, 255));
			6: return $urandom_range(0, 1) ? 8'hff : 8'h00;
			default: return $urandom_range(0, 1) ? kbd_pkg::PrintHigh : kbd_pkg::PrintLow;
		endcase
	endfunction

	// random beat; fill mode favors appends, otherwise pops dominate
	function automatic void random_item(input logic fill, output logic [2:0] kind,
			output key_fields_t f);
		int r;
		logic [2:0] spare;
		r = $urandom_range(0, 199);
		spare = $urandom_range(0, 1) ? KindSpareHi : KindSpareLo;
		if (fill)
			kind = r < 1 ? kbd_pkg::KIND_CLEAR : r < 7 ? spare :
				r < 87 ? kbd_pkg::KIND_KEY : r < 127 ? kbd_pkg::KIND_CHAR :
				r < 151 ? kbd_pkg::KIND_POP : r < 181 ? kbd_pkg::KIND_TEST : kbd_pkg::KIND_TICK;
		else
			kind = r < 4 ? kbd_pkg::KIND_CLEAR : r < 10 ? spare :
				r < 50 ? kbd_pkg::KIND_KEY : r < 66 ? kbd_pkg::KIND_CHAR :
				r < 146 ? kbd_pkg::KIND_POP : r < 176 ? kbd_pkg::KIND_TEST : kbd_pkg::KIND_TICK;
		f.key = (kind == kbd_pkg::KIND_CHAR) ? 8'($urandom_range(0, 255)) : pick_key();
		f.side = 1'($urandom_range(0, 1));
		f.down = ($urandom_range(0, 9) < 6);
	endfunction

	// present one beat in bursts with random gaps, predict on accept
	task automatic send_item(input logic [2:0] kind, input key_fields_t f, input logic typed,
			input kbd_result_t want);
		logic has_res;
		kbd_result_t res;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'b0, f};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		keyboard_response(kind, f, has_res, res);
		if (has_res)
			awaited_responses.push_back(typed ? want : res);
	endtask

	// drop valid and wait until every result is back and the pipe is empty
	task automatic wait_quiet(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read the message register back and compare with the shadow copy
	task automatic check_msg_reg();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MsgAddr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0, irq_msg})
			flag_error($sformatf("irq_message readback exp %h got %h", irq_msg, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_irq_message(input logic [15:0] msg);
		wait_quiet(6);
		reg_write(MsgAddr, {16'h0, msg});
		irq_msg = msg;
		check_msg_reg();
	endtask

	// a write to the unused address must leave the message alone
	task automatic write_spare(input logic [31:0] data);
		wait_quiet(6);
		reg_write(SpareAddr, data);
		check_msg_reg();
	endtask

	// output side stall pattern
	int stall_mode = 0, stall_left = 0, hold_left = 0, stall_tick = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(64, 256);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ((stall_tick % 3) != 0);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					hold_left = $urandom_range(0, 7);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		kbd_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[25:0];
			beats_checked++;
			if (awaited_responses.size() == 0) begin
				flag_error($sformatf("result beat %h with nothing expected", m_tdata));
			end else begin
				want = awaited_responses.pop_front();
				if (got.read_data !== want.read_data || got.is_down !== want.is_down ||
						got.irq_fire !== want.irq_fire || got.irq_value !== want.irq_value ||
						m_tdata[31:26] !== 6'b0)
					flag_error($sformatf({"read_data %h/%h is_down %b/%b irq_fire %b/%b ",
						"irq_value %h/%h pad %h (exp/got)"}, want.read_data, got.read_data,
						want.is_down, got.is_down, want.irq_fire, got.irq_fire,
						want.irq_value, got.irq_value, m_tdata[31:26]));
				if (got.irq_fire)
					irqs_seen++;
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IdleLimit) begin
			$display("timeout after %0d quiet cycles", IdleLimit);
			$display("keyboard_ring_buffer_device regression: fail");
			$finish;
		end
	end

	// main sequence
	initial begin
		dir_row_t dir_rows [$];
		logic [2:0] kind;
		key_fields_t f;
		logic [15:0] msg;

		dir_rows = '{
			// empty queue and released map after reset
			'{ROW_ITEM, kbd_pkg::KIND_POP, 8'h00, 1'b0, 1'b0, 32'h0, 1'b1, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TEST, 8'h41, 1'b0, 1'b0, 32'h0, 1'b1, NoBeat},
			// key zero and the top code are queued
			'{ROW_ITEM, kbd_pkg::KIND_KEY, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, 8'hff, 1'b1, 1'b1, 32'h0, 1'b0, NoBeat},
			// uppercase press mirrors to lowercase
			'{ROW_ITEM, kbd_pkg::KIND_KEY, 8'h41, 1'b0, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TEST, 8'h61, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			// test of key zero answers released
			'{ROW_ITEM, kbd_pkg::KIND_TEST, 8'h00, 1'b0, 1'b0, 32'h0, 1'b1, NoBeat},
			// merged shift: left up while right still down
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::KeyShift, 1'b0, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::KeyShift, 1'b1, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::KeyShift, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TEST, kbd_pkg::KeyShift, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::KeyControl, 1'b1, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_CHAR, kbd_pkg::PrintHigh, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			// unused kind is ignored
			'{ROW_ITEM, KindSpareHi, 8'hff, 1'b1, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_POP, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_POP, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			// clear empties the queue
			'{ROW_ITEM, kbd_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_POP, 8'h00, 1'b0, 1'b0, 32'h0, 1'b1, NoBeat},
			// interrupt with the largest message
			'{ROW_MSG_WRITE, kbd_pkg::KIND_KEY, 8'h00, 1'b0, 1'b0, 32'h0000_ffff, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::PrintLow, 1'b0, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b1,
				'{16'hffff, 1'b1, 1'b0, 8'h00}},
			// armed, then the message is cleared: the tick only drops the pending flag
			'{ROW_ITEM, kbd_pkg::KIND_KEY, 8'h5a, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_MSG_WRITE, kbd_pkg::KIND_KEY, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_MSG_WRITE, kbd_pkg::KIND_KEY, 8'h00, 1'b0, 1'b0, 32'h0000_0001, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_KEY, kbd_pkg::PrintHigh, 1'b0, 1'b1, 32'h0, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0, 1'b1,
				'{16'h0001, 1'b1, 1'b0, 8'h00}},
			'{ROW_SPARE_WRITE, kbd_pkg::KIND_KEY, 8'h00, 1'b0, 1'b0, 32'hffff_ffff, 1'b0, NoBeat},
			'{ROW_ITEM, kbd_pkg::KIND_TEST, 8'hff, 1'b0, 1'b0, 32'h0, 1'b0, NoBeat}
		};

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_MSG_WRITE: set_irq_message(dir_rows[i].value[15:0]);
				ROW_SPARE_WRITE: write_spare(dir_rows[i].value);
				default: begin
					f = {dir_rows[i].down, dir_rows[i].side, dir_rows[i].key};
					send_item(dir_rows[i].kind, f, dir_rows[i].typed, dir_rows[i].want);
				end
			endcase
		end

		// random phases, alternating fill and drain, each with its own message
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: msg = 16'h0001;
				1: msg = 16'h0000;
				2: msg = 16'hffff;
				3: msg = 16'h8000;
				default: msg = 16'($urandom_range(0, 65535));
			endcase
			set_irq_message(msg);
			if (ph == 5)
				write_spare($urandom);
			for (int n = 0; n < PhaseItems; n++) begin
				random_item(ph % 2 == 0, kind, f);
				send_item(kind, f, 1'b0, NoBeat);
			end
		end

		wait_quiet(10);
		$display("sent %0d beats, checked %0d results, %0d interrupts delivered",
			items_sent, beats_checked, irqs_seen);
		$display("queue overflow drops %0d, tests that found a key down %0d",
			fifo_drops, keys_found_down);
		if (mismatch_count == 0)
			$display("keyboard_ring_buffer_device regression: pass");
		else
			$display("keyboard_ring_buffer_device regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/kbd_pkg.sv
rtl/kbd_ram.sv
rtl/kbd_queue.sv
rtl/kbd_map.sv
rtl/keyboard_ring_buffer_device.sv
bench/keyboard_ring_buffer_device_tb.sv
